[src/owm_pkg.sv]
package owm_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 3;

  // command field on the input stream
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_RESET_REL   = 3'd1,
    REG_SHORT       = 3'd2,
    REG_LONG        = 3'd3,
    REG_SAMPLE_WAIT = 3'd4,
    REG_READ_REC    = 3'd5
  } reg_idx_e;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_RST_LOW = 8'b0000_0010,
    PH_RST_REL = 8'b0000_0100,
    PH_WR_LOW  = 8'b0000_1000,
    PH_WR_REL  = 8'b0001_0000,
    PH_RD_LOW  = 8'b0010_0000,
    PH_RD_WAIT = 8'b0100_0000,
    PH_RD_REC  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [CntW-1:0] reset_low_ticks;
    logic [CntW-1:0] reset_release_ticks;
    logic [CntW-1:0] short_ticks;
    logic [CntW-1:0] long_ticks;
    logic [CntW-1:0] sample_wait_ticks;
    logic [CntW-1:0] read_recover_ticks;
  } cfg_t;

  typedef struct packed {
    logic             received_valid;
    logic [ByteW-1:0] received_byte;
    logic             busy_res;
    logic             pull_low;
  } result_t;

  // a zero length phase still lasts one tick
  function automatic logic [CntW-1:0] len_of(input logic [CntW-1:0] v);
    len_of = (v == '0) ? CntW'(1) : v;
  endfunction

endpackage

[src/one_wire_master_slot_engine.sv]
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the next beat is taken while a result
// waits, as long as the output register is free or drained in that cycle.
// Reset (rst_ni low, asynchronous): engine idle, counters and bytes cleared,
// timing registers back to their defaults, no result pending.
module one_wire_master_slot_engine
  import owm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [15:0]        s_axis_tdata_i,  // [7:0] send_byte, [8] line_level
  input  logic [1:0]         s_axis_tuser_i,  // [1:0] kind
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [0] pull_low, [1] busy_res, [9:2] received_byte, [10] received_valid
  output logic [15:0]        m_axis_tdata_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    step;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks     <= CntW'(385);
      cfg_q.reset_release_ticks <= CntW'(66);
      cfg_q.short_ticks         <= CntW'(1);
      cfg_q.long_ticks          <= CntW'(66);
      cfg_q.sample_wait_ticks   <= CntW'(10);
      cfg_q.read_recover_ticks  <= CntW'(45);
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RESET_LOW:   cfg_q.reset_low_ticks     <= cfg_data_i;
        REG_RESET_REL:   cfg_q.reset_release_ticks <= cfg_data_i;
        REG_SHORT:       cfg_q.short_ticks         <= cfg_data_i;
        REG_LONG:        cfg_q.long_ticks          <= cfg_data_i;
        REG_SAMPLE_WAIT: cfg_q.sample_wait_ticks   <= cfg_data_i;
        REG_READ_REC:    cfg_q.read_recover_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  owm_slot_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .kind_i       (s_axis_tuser_i),
    .send_byte_i  (s_axis_tdata_i[ByteW-1:0]),
    .line_level_i (s_axis_tdata_i[ByteW]),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // hold the result beat until the sink takes it
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q};

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result beat stalled");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(cfg_q))
    else $error("timing register changed without a write");

endmodule

[src/owm_slot_core.sv]
module owm_slot_core
  import owm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       kind_i,
  input  logic [ByteW-1:0] send_byte_i,
  input  logic             line_level_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    tick_q, tick_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   rx_q, rx_d;

  phase_e             cur_phase;
  logic [CntW-1:0]    cur_tick;
  logic [BitIdxW-1:0] cur_bit;
  logic [ByteW-1:0]   cur_shift;
  logic [CntW-1:0]    len;
  logic               tx_bit;
  logic               done;
  logic               start;
  kind_e              kind;

  assign kind  = kind_e'(kind_i);
  assign start = (phase_q == PH_IDLE) && (kind != KIND_TICK);

  // launch a command on the same tick it arrives
  always_comb begin
    cur_phase = phase_q;
    cur_tick  = tick_q;
    cur_bit   = bit_q;
    cur_shift = shift_q;
    if (start) begin
      cur_tick  = '0;
      cur_bit   = '0;
      cur_shift = '0;
      unique case (kind)
        KIND_RESET: cur_phase = PH_RST_LOW;
        KIND_WRITE: begin
          cur_phase = PH_WR_LOW;
          cur_shift = send_byte_i;
        end
        KIND_READ:  cur_phase = PH_RD_LOW;
        default:    cur_phase = phase_q;
      endcase
    end
  end

  assign tx_bit = cur_shift[cur_bit];

  always_comb begin
    unique case (cur_phase)
      PH_RST_LOW: len = len_of(cfg_i.reset_low_ticks);
      PH_RST_REL: len = len_of(cfg_i.reset_release_ticks);
      PH_WR_LOW:  len = tx_bit ? len_of(cfg_i.short_ticks) : len_of(cfg_i.long_ticks);
      PH_WR_REL:  len = tx_bit ? len_of(cfg_i.long_ticks) : len_of(cfg_i.short_ticks);
      PH_RD_LOW:  len = len_of(cfg_i.short_ticks);
      PH_RD_WAIT: len = len_of(cfg_i.sample_wait_ticks);
      PH_RD_REC:  len = len_of(cfg_i.read_recover_ticks);
      default:    len = CntW'(1);
    endcase
  end

  assign done = ({1'b0, cur_tick} + (CntW+1)'(1)) >= {1'b0, len};

  always_comb begin
    phase_d = cur_phase;
    tick_d  = cur_tick;
    bit_d   = cur_bit;
    shift_d = cur_shift;
    rx_d    = rx_q;
    res_o.pull_low       = (cur_phase == PH_RST_LOW) || (cur_phase == PH_WR_LOW) ||
                           (cur_phase == PH_RD_LOW);
    res_o.busy_res       = (cur_phase != PH_IDLE);
    res_o.received_valid = 1'b0;
    if (cur_phase != PH_IDLE) begin
      if (!done) begin
        tick_d = cur_tick + CntW'(1);
      end else begin
        tick_d = '0;
        unique case (cur_phase)
          PH_RST_LOW: phase_d = PH_RST_REL;
          PH_RST_REL: phase_d = PH_IDLE;
          PH_WR_LOW:  phase_d = PH_WR_REL;
          PH_WR_REL: begin
            if (cur_bit == '1) begin
              phase_d = PH_IDLE;
            end else begin
              bit_d   = cur_bit + BitIdxW'(1);
              phase_d = PH_WR_LOW;
            end
          end
          PH_RD_LOW:  phase_d = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shift_d          = cur_shift;
            shift_d[cur_bit] = cur_shift[cur_bit] | line_level_i;
            phase_d          = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (cur_bit == '1) begin
              rx_d                 = cur_shift;
              res_o.received_valid = 1'b1;
              phase_d              = PH_IDLE;
            end else begin
              bit_d   = cur_bit + BitIdxW'(1);
              phase_d = PH_RD_LOW;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
    res_o.received_byte = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      rx_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
    end
  end

  a_pull_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.pull_low |-> res_o.busy_res)
    else $error("line driven low outside an operation");

  a_rx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.received_valid) |=> (phase_q == PH_IDLE))
    else $error("read completion did not return to idle");

  a_rx_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.received_valid) |=> (rx_q == $past(shift_q)))
    else $error("received byte differs from assembled byte");

endmodule
